/* design/tapc_pkg.sv */
// shared types and constants for the triangle axis plane clipper
package tapc_pkg;

   // default geometry of the datapath
   localparam int DEF_COORD_BITS      = 32;
   localparam int DEF_FRAC_BITS       = 16;
   localparam int DEF_RATIO_FRAC_BITS = 24;

   // quotient bits resolved per divider stage
   localparam int DIV_STEP_BITS = 3;

   // register indexes on the csr port
   localparam logic [1:0] REG_CLIP_AXIS      = 2'd0;
   localparam logic [1:0] REG_PLANE_POSITION = 2'd1;
   localparam logic [1:0] REG_KEEP_BELOW     = 2'd2;

   // axis codes, anything else means z
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   typedef enum logic [2:0] {
      MODE_PASS,
      MODE_ONE_BELOW,
      MODE_ONE_ABOVE,
      MODE_TWO_BELOW,
      MODE_TWO_ABOVE
   } mode_type;

   typedef enum logic [1:0] {
      SEL_START,
      SEL_END,
      SEL_MIX
   } sel_type;

   typedef struct packed {
      logic ratio_one;
      logic tiny_edge;
   } div_flags_type;

endpackage

/* design/tapc_if.sv */
// valid/ready channels carrying triangle words in and out
interface tapc_req_if #(parameter int COORD_BITS = tapc_pkg::DEF_COORD_BITS);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
   logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
   logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;

   modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                   input ready);
   modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                   output ready);
endinterface

interface tapc_rsp_if #(parameter int COORD_BITS = tapc_pkg::DEF_COORD_BITS);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] r0_x, r0_y, r0_z;
   logic signed [COORD_BITS-1:0] r1_x, r1_y, r1_z;
   logic signed [COORD_BITS-1:0] r2_x, r2_y, r2_z;
   logic                         last_of_run;

   modport source (output valid, r0_x, r0_y, r0_z, r1_x, r1_y, r1_z, r2_x, r2_y, r2_z,
                   last_of_run, input ready);
   modport sink   (input valid, r0_x, r0_y, r0_z, r1_x, r1_y, r1_z, r2_x, r2_y, r2_z,
                   last_of_run, output ready);
endinterface

/* design/triangle_axis_plane_clipper_unit.sv */
// triangle clipper against one axis-aligned plane, top level
//
//  channel   dir  handshake                      word
//  req_chan  in   valid/ready                    three vertices, signed q16.16
//  rsp_chan  out  valid/ready                    one result triangle + last_of_run
//  csr_*     in   apb write (setup + access)     clip_axis, plane_position, keep_below
//
// the pipeline runs capture, classify, divider entry, one divider stage per three
// ratio bits, snap, multiply, interpolate and output.
// a triangle may enter every cycle unless a stalled result port or a two-result triangle backs up the pipe;
// the single result port sets the sustained rate and sends two results one at a time.
// reset clears the valid bits and loads the csr defaults (axis x, plane 0, keep below).
// each stage advances when it is empty or the stage after it advances, so a stalled
// result port backs up only full stages and bubbles close up.
module triangle_axis_plane_clipper_unit #(
   parameter int  COORD_BITS      = tapc_pkg::DEF_COORD_BITS,
   parameter int  FRAC_BITS       = tapc_pkg::DEF_FRAC_BITS,
   parameter int  RATIO_FRAC_BITS = tapc_pkg::DEF_RATIO_FRAC_BITS,
   localparam int CSR_DATA_BITS   = (COORD_BITS > 32) ? 64 : 32,
   localparam int CSR_ADDR_LSB    = (COORD_BITS > 32) ? 3 : 2,
   localparam int CSR_ADDR_BITS   = CSR_ADDR_LSB + 2
) (
   input  logic                     clock,
   input  logic                     reset,
   tapc_req_if.sink                 req_chan,
   tapc_rsp_if.source               rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);
   import tapc_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int MB   = COORD_BITS + 1;     // magnitude of a coordinate difference
   localparam int RFB  = RATIO_FRAC_BITS;
   localparam int PB   = MB + RFB;           // product width
   localparam int DIV_STAGES = (RFB + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int EDGE_MIN   = ((1 << FRAC_BITS) + 99999) / 100000;

   localparam logic [RFB:0] RATIO_ONE = (RFB+1)'(longint'(1) << RATIO_FRAC_BITS);
   localparam logic [RFB:0] SNAP      =
      (RFB+1)'(((longint'(1) << RATIO_FRAC_BITS) + 99999) / 100000);
   localparam logic [RFB:0] SNAP_HIGH = RATIO_ONE - SNAP;
   localparam logic [PB:0]  HALF      = (PB+1)'(longint'(1) << (RATIO_FRAC_BITS - 1));

   // stage positions in the valid chain
   localparam int ST_CAP  = 0;
   localparam int ST_CLS  = 1;
   localparam int ST_DIV  = 2;
   localparam int ST_SNAP = ST_DIV + DIV_STAGES + 1;
   localparam int ST_MUL  = ST_SNAP + 1;
   localparam int ST_FIN  = ST_MUL + 1;
   localparam int NPIPE   = ST_FIN + 1;

   typedef struct packed {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic signed [CB-1:0] z;
   } vert_type;

   typedef struct packed {
      vert_type a;
      vert_type b;
      vert_type c;
      mode_type mode;
   } tri_sb_type;

   typedef struct packed {
      vert_type v0;
      vert_type v1;
      vert_type v2;
   } tri_type;

   function automatic logic signed [CB-1:0] pick(input vert_type v, input logic [1:0] ax);
      logic signed [CB-1:0] r;
      if (ax == AXIS_X) begin
         r = v.x;
      end else if (ax == AXIS_Y) begin
         r = v.y;
      end else begin
         r = v.z;
      end
      return r;
   endfunction

   function automatic logic [MB-1:0] mag(input logic signed [CB:0] v);
      return v[CB] ? MB'(-v) : MB'(v);
   endfunction

   function automatic logic signed [CB:0] diff(input logic signed [CB-1:0] hi,
                                               input logic signed [CB-1:0] lo);
      return {hi[CB-1], hi} - {lo[CB-1], lo};
   endfunction

   // start point of the second cut: b->c with one vertex above, a->c with two
   function automatic vert_type q_start(input tri_sb_type sb);
      return (sb.mode == MODE_ONE_BELOW || sb.mode == MODE_ONE_ABOVE) ? sb.b : sb.a;
   endfunction

   function automatic sel_type snap_sel(input logic [RFB:0] r, input div_flags_type f);
      sel_type s;
      if (f.tiny_edge || r < SNAP) begin
         s = SEL_START;
      end else if (r > SNAP_HIGH) begin
         s = SEL_END;
      end else begin
         s = SEL_MIX;
      end
      return s;
   endfunction

   // ---------------------------------------------------------------- csr
   logic [1:0]          clip_axis_ff;
   logic signed [CB-1:0] plane_position_ff;
   logic                keep_below_ff;
   logic                csr_write;
   logic [1:0]          csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_BITS-1:CSR_ADDR_LSB];

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_axis_ff      <= AXIS_X;
         plane_position_ff <= '0;
         keep_below_ff     <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CLIP_AXIS:      clip_axis_ff      <= csr_pwdata[1:0];
            REG_PLANE_POSITION: plane_position_ff <= csr_pwdata[CB-1:0];
            REG_KEEP_BELOW:     keep_below_ff     <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CLIP_AXIS:      csr_prdata = CSR_DATA_BITS'(clip_axis_ff);
         REG_PLANE_POSITION: csr_prdata = CSR_DATA_BITS'(plane_position_ff);
         REG_KEEP_BELOW:     csr_prdata = CSR_DATA_BITS'(keep_below_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- stall chain
   logic [NPIPE-1:0] vld_ff;
   logic [NPIPE:0]   en;
   logic             out_en;
   logic             drop;

   always_comb begin
      en[NPIPE] = out_en;
      for (int i = NPIPE - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_chan.ready = en[ST_CAP];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[ST_CAP]) vld_ff[ST_CAP] <= req_chan.valid;
         // triangles wholly on the discarded side leave here
         if (en[ST_CLS]) vld_ff[ST_CLS] <= vld_ff[ST_CAP] && !drop;
         for (int i = ST_DIV; i < NPIPE; i++) begin
            if (en[i]) vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- capture
   vert_type   vin [3];
   vert_type   v_ff [3];
   logic [2:0] up_ff;

   assign vin[0] = {req_chan.v0_x, req_chan.v0_y, req_chan.v0_z};
   assign vin[1] = {req_chan.v1_x, req_chan.v1_y, req_chan.v1_z};
   assign vin[2] = {req_chan.v2_x, req_chan.v2_y, req_chan.v2_z};

   always_ff @(posedge clock) begin
      if (en[ST_CAP]) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i]  <= vin[i];
            up_ff[i] <= pick(vin[i], clip_axis_ff) > plane_position_ff;
         end
      end
   end

   // ---------------------------------------------------------------- classify
   // for a triangle that crosses the plane, rotate so that a is at or below it and b is above, winding kept
   logic [1:0]  up_cnt;
   logic [1:0]  rot;
   tri_sb_type  sb_cls;
   vert_type    cls_qa;
   tri_sb_type  sb2_ff;
   logic [MB-1:0] np_ff, dp_ff, nq_ff, dq_ff;

   always_comb begin
      up_cnt = 2'(up_ff[0]) + 2'(up_ff[1]) + 2'(up_ff[2]);
      drop   = (up_cnt == 2'd0 && !keep_below_ff) || (up_cnt == 2'd3 && keep_below_ff);
      priority if (up_cnt == 2'd0 || up_cnt == 2'd3) begin
         rot = 2'd0;
      end else if (!up_ff[0] && up_ff[1]) begin
         rot = 2'd0;
      end else if (!up_ff[1] && up_ff[2]) begin
         rot = 2'd1;
      end else begin
         rot = 2'd2;
      end
      unique case (rot)
         2'd0:    begin sb_cls.a = v_ff[0]; sb_cls.b = v_ff[1]; sb_cls.c = v_ff[2]; end
         2'd1:    begin sb_cls.a = v_ff[1]; sb_cls.b = v_ff[2]; sb_cls.c = v_ff[0]; end
         default: begin sb_cls.a = v_ff[2]; sb_cls.b = v_ff[0]; sb_cls.c = v_ff[1]; end
      endcase
      unique case (up_cnt)
         2'd1:    sb_cls.mode = keep_below_ff ? MODE_ONE_BELOW : MODE_ONE_ABOVE;
         2'd2:    sb_cls.mode = keep_below_ff ? MODE_TWO_BELOW : MODE_TWO_ABOVE;
         default: sb_cls.mode = MODE_PASS;
      endcase
      cls_qa = q_start(sb_cls);
   end

   always_ff @(posedge clock) begin
      if (en[ST_CLS]) begin
         sb2_ff <= sb_cls;
         np_ff  <= mag(diff(plane_position_ff, pick(sb_cls.a, clip_axis_ff)));
         dp_ff  <= mag(diff(pick(sb_cls.b, clip_axis_ff), pick(sb_cls.a, clip_axis_ff)));
         nq_ff  <= mag(diff(plane_position_ff, pick(cls_qa, clip_axis_ff)));
         dq_ff  <= mag(diff(pick(sb_cls.c, clip_axis_ff), pick(cls_qa, clip_axis_ff)));
      end
   end

   // ---------------------------------------------------------------- divide
   logic [RFB:0]  ratio_p, ratio_q;
   div_flags_type flags_p, flags_q;
   tri_sb_type    sbd_ff [DIV_STAGES+1];

   tapc_div #(.MAG_BITS(MB), .RATIO_BITS(RFB), .EDGE_MIN(EDGE_MIN)) u_div_p (
      .clock    (clock),
      .stage_en (en[ST_DIV +: DIV_STAGES+1]),
      .num_mag  (np_ff),
      .den_mag  (dp_ff),
      .ratio    (ratio_p),
      .flags    (flags_p)
   );

   tapc_div #(.MAG_BITS(MB), .RATIO_BITS(RFB), .EDGE_MIN(EDGE_MIN)) u_div_q (
      .clock    (clock),
      .stage_en (en[ST_DIV +: DIV_STAGES+1]),
      .num_mag  (nq_ff),
      .den_mag  (dq_ff),
      .ratio    (ratio_q),
      .flags    (flags_q)
   );

   // triangle rides alongside the divider stages
   always_ff @(posedge clock) begin
      if (en[ST_DIV]) sbd_ff[0] <= sb2_ff;
      for (int j = 1; j <= DIV_STAGES; j++) begin
         if (en[ST_DIV+j]) sbd_ff[j] <= sbd_ff[j-1];
      end
   end

   // ---------------------------------------------------------------- snap
   tri_sb_type    sb_div;
   vert_type      snap_qa;
   tri_sb_type    sbs_ff;
   sel_type       selp_s_ff, selq_s_ff;
   logic [RFB-1:0] ratp_ff, ratq_ff;
   logic [MB-1:0] magp_ff [3];
   logic [MB-1:0] magq_ff [3];
   logic [2:0]    negp_s_ff, negq_s_ff;
   logic signed [CB:0] dp_comp [3];
   logic signed [CB:0] dq_comp [3];

   assign sb_div  = sbd_ff[DIV_STAGES];
   assign snap_qa = q_start(sb_div);

   always_comb begin
      dp_comp[0] = diff(sb_div.b.x, sb_div.a.x);
      dp_comp[1] = diff(sb_div.b.y, sb_div.a.y);
      dp_comp[2] = diff(sb_div.b.z, sb_div.a.z);
      dq_comp[0] = diff(sb_div.c.x, snap_qa.x);
      dq_comp[1] = diff(sb_div.c.y, snap_qa.y);
      dq_comp[2] = diff(sb_div.c.z, snap_qa.z);
   end

   always_ff @(posedge clock) begin
      if (en[ST_SNAP]) begin
         sbs_ff    <= sb_div;
         selp_s_ff <= snap_sel(ratio_p, flags_p);
         selq_s_ff <= snap_sel(ratio_q, flags_q);
         ratp_ff   <= ratio_p[RFB-1:0];
         ratq_ff   <= ratio_q[RFB-1:0];
         for (int k = 0; k < 3; k++) begin
            magp_ff[k]   <= mag(dp_comp[k]);
            magq_ff[k]   <= mag(dq_comp[k]);
            negp_s_ff[k] <= dp_comp[k][CB];
            negq_s_ff[k] <= dq_comp[k][CB];
         end
      end
   end

   // ---------------------------------------------------------------- multiply
   tri_sb_type  sbm_ff;
   sel_type     selp_m_ff, selq_m_ff;
   logic [PB-1:0] prodp_ff [3];
   logic [PB-1:0] prodq_ff [3];
   logic [2:0]  negp_m_ff, negq_m_ff;

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         sbm_ff    <= sbs_ff;
         selp_m_ff <= selp_s_ff;
         selq_m_ff <= selq_s_ff;
         negp_m_ff <= negp_s_ff;
         negq_m_ff <= negq_s_ff;
         for (int k = 0; k < 3; k++) begin
            prodp_ff[k] <= PB'(magp_ff[k]) * PB'(ratp_ff);
            prodq_ff[k] <= PB'(magq_ff[k]) * PB'(ratq_ff);
         end
      end
   end

   // ---------------------------------------------------------------- interpolate
   function automatic logic signed [CB-1:0] lerp(input logic signed [CB-1:0] st,
                                                 input logic [PB-1:0] prod,
                                                 input logic neg);
      logic [PB:0]          rounded;
      logic signed [CB+1:0] step;
      logic signed [CB+1:0] sum;
      rounded = ({1'b0, prod} + HALF) >> RFB;
      step    = (CB+2)'(rounded[MB-1:0]);
      sum     = neg ? {{2{st[CB-1]}}, st} - step : {{2{st[CB-1]}}, st} + step;
      return sum[CB-1:0];
   endfunction

   function automatic vert_type cut_point(input vert_type st, input vert_type fin,
                                          input sel_type sel, input logic [PB-1:0] px,
                                          input logic [PB-1:0] py, input logic [PB-1:0] pz,
                                          input logic [2:0] neg);
      vert_type o;
      unique case (sel)
         SEL_START: o = st;
         SEL_END:   o = fin;
         default: begin
            o.x = lerp(st.x, px, neg[0]);
            o.y = lerp(st.y, py, neg[1]);
            o.z = lerp(st.z, pz, neg[2]);
         end
      endcase
      return o;
   endfunction

   tri_sb_type sbf_ff;
   vert_type   p_ff, q_ff;

   always_ff @(posedge clock) begin
      if (en[ST_FIN]) begin
         sbf_ff <= sbm_ff;
         p_ff   <= cut_point(sbm_ff.a, sbm_ff.b, selp_m_ff,
                             prodp_ff[0], prodp_ff[1], prodp_ff[2], negp_m_ff);
         q_ff   <= cut_point(q_start(sbm_ff), sbm_ff.c, selq_m_ff,
                             prodq_ff[0], prodq_ff[1], prodq_ff[2], negq_m_ff);
      end
   end

   // ---------------------------------------------------------------- output
   tri_type tri0_in, tri1_in, tri0_ff, tri1_ff, tri_out;
   logic    two_in, two_ff;
   logic    o_vld_ff, o_idx_ff;

   always_comb begin
      tri1_in = '{v0: p_ff, v1: sbf_ff.b, v2: q_ff};
      unique case (sbf_ff.mode)
         MODE_PASS: begin
            tri0_in = '{v0: sbf_ff.a, v1: sbf_ff.b, v2: sbf_ff.c};
            two_in  = 1'b0;
         end
         MODE_ONE_BELOW: begin
            tri0_in = '{v0: sbf_ff.a, v1: p_ff, v2: q_ff};
            tri1_in = '{v0: sbf_ff.a, v1: q_ff, v2: sbf_ff.c};
            two_in  = 1'b1;
         end
         MODE_ONE_ABOVE: begin
            tri0_in = '{v0: p_ff, v1: sbf_ff.b, v2: q_ff};
            two_in  = 1'b0;
         end
         MODE_TWO_BELOW: begin
            tri0_in = '{v0: sbf_ff.a, v1: p_ff, v2: q_ff};
            two_in  = 1'b0;
         end
         default: begin
            tri0_in = '{v0: p_ff, v1: sbf_ff.b, v2: q_ff};
            tri1_in = '{v0: q_ff, v1: sbf_ff.b, v2: sbf_ff.c};
            two_in  = 1'b1;
         end
      endcase
   end

   // output word holds until its last triangle is taken
   assign rsp_chan.last_of_run = !two_ff || o_idx_ff;
   assign out_en = !o_vld_ff || (rsp_chan.ready && rsp_chan.last_of_run);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
         o_idx_ff <= 1'b0;
      end else if (out_en) begin
         o_vld_ff <= vld_ff[ST_FIN];
         o_idx_ff <= 1'b0;
      end else if (rsp_chan.ready) begin
         o_idx_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         tri0_ff <= tri0_in;
         tri1_ff <= tri1_in;
         two_ff  <= two_in;
      end
   end

   assign tri_out        = o_idx_ff ? tri1_ff : tri0_ff;
   assign rsp_chan.valid = o_vld_ff;
   assign rsp_chan.r0_x  = tri_out.v0.x;
   assign rsp_chan.r0_y  = tri_out.v0.y;
   assign rsp_chan.r0_z  = tri_out.v0.z;
   assign rsp_chan.r1_x  = tri_out.v1.x;
   assign rsp_chan.r1_y  = tri_out.v1.y;
   assign rsp_chan.r1_z  = tri_out.v1.z;
   assign rsp_chan.r2_x  = tri_out.v2.x;
   assign rsp_chan.r2_y  = tri_out.v2.y;
   assign rsp_chan.r2_z  = tri_out.v2.z;

endmodule

/* design/tapc_div.sv */
// pipelined restoring divider producing the edge cut ratio
module tapc_div #(
   parameter int  MAG_BITS   = tapc_pkg::DEF_COORD_BITS + 1,
   parameter int  RATIO_BITS = tapc_pkg::DEF_RATIO_FRAC_BITS,
   parameter int  EDGE_MIN   = 1,
   localparam int STAGES     = (RATIO_BITS + tapc_pkg::DIV_STEP_BITS - 1) /
                               tapc_pkg::DIV_STEP_BITS
) (
   input  logic                          clock,
   input  logic [STAGES:0]               stage_en,
   input  logic [MAG_BITS-1:0]           num_mag,
   input  logic [MAG_BITS-1:0]           den_mag,
   output logic [RATIO_BITS:0]           ratio,
   output tapc_pkg::div_flags_type       flags
);
   import tapc_pkg::*;

   logic [MAG_BITS-1:0]   rem_ff [STAGES+1];
   logic [MAG_BITS-1:0]   den_ff [STAGES+1];
   logic [RATIO_BITS-1:0] quo_ff [STAGES+1];
   div_flags_type         flg_ff [STAGES+1];

   // entry: classify the edge, start with remainder = numerator
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rem_ff[0]           <= num_mag;
         den_ff[0]           <= den_mag;
         quo_ff[0]           <= '0;
         flg_ff[0].ratio_one <= (num_mag >= den_mag);
         flg_ff[0].tiny_edge <= (den_mag < MAG_BITS'(EDGE_MIN));
      end
   end

   for (genvar s = 1; s <= STAGES; s++) begin : g_step
      logic [MAG_BITS-1:0]   rem_in;
      logic [RATIO_BITS-1:0] quo_in;

      always_comb begin
         logic [MAG_BITS:0]     sh;
         logic [MAG_BITS-1:0]   r;
         logic [RATIO_BITS-1:0] q;
         r  = rem_ff[s-1];
         q  = quo_ff[s-1];
         sh = '0;
         for (int j = 0; j < DIV_STEP_BITS; j++) begin
            if ((s - 1) * DIV_STEP_BITS + j < RATIO_BITS) begin
               sh = {r, 1'b0};
               if (sh >= {1'b0, den_ff[s-1]}) begin
                  sh = sh - {1'b0, den_ff[s-1]};
                  q  = {q[RATIO_BITS-2:0], 1'b1};
               end else begin
                  q  = {q[RATIO_BITS-2:0], 1'b0};
               end
               r = sh[MAG_BITS-1:0];
            end
         end
         rem_in = r;
         quo_in = q;
      end

      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_ff[s-1];
            quo_ff[s] <= quo_in;
            flg_ff[s] <= flg_ff[s-1];
         end
      end
   end

   assign flags = flg_ff[STAGES];
   assign ratio = flg_ff[STAGES].ratio_one ? {1'b1, {RATIO_BITS{1'b0}}}
                                           : {1'b0, quo_ff[STAGES]};

endmodule

/* tb/tapc_scoreboard.sv */
// scoreboard class: predicts clipped triangles and checks result words
class tapc_scoreboard;
   typedef struct {
      logic [31:0] f [9];
      logic        last;
   } tri_word_type;

   tri_word_type pending_tris[$];
   logic [1:0]  axis_sel;
   logic signed [31:0] plane;
   logic        keep_lo;
   int          mismatches;

   function new();
      axis_sel = 0;
      plane = 0;
      keep_lo = 1;
      mismatches = 0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] val);
      unique case (idx)
         tapc_pkg::REG_CLIP_AXIS:      axis_sel = val[1:0];
         tapc_pkg::REG_PLANE_POSITION: plane = val;
         tapc_pkg::REG_KEEP_BELOW:     keep_lo = val[0];
         default: ;
      endcase
   endfunction

   // cut point on edge a->b along the chosen axis
   function void cut_edge(input longint a[3], input longint b[3], input int ax,
                          output longint o[3]);
      longint den, num, d;
      longint unsigned dm, nm, ratio, rem, mag;
      logic [127:0] prod;
      den = b[ax] - a[ax];
      num = longint'(plane) - a[ax];
      dm = den < 0 ? -den : den;
      nm = num < 0 ? -num : num;
      if (dm < 1) begin
         o = a;
         return;
      end
      if (nm >= dm) begin
         ratio = 64'd1 << 24;
      end else begin
         rem = nm;
         ratio = 0;
         for (int k = 0; k < 24; k++) begin
            rem = rem << 1;
            ratio = ratio << 1;
            if (rem >= dm) begin
               rem -= dm;
               ratio |= 1;
            end
         end
      end
      if (ratio < 168) begin
         o = a;
         return;
      end
      if (ratio > (64'd1 << 24) - 168) begin
         o = b;
         return;
      end
      for (int k = 0; k < 3; k++) begin
         d = b[k] - a[k];
         mag = d < 0 ? -d : d;
         prod = (128'(mag) * 128'(ratio) + (128'd1 << 23)) >> 24;
         o[k] = a[k] + (d < 0 ? -longint'(prod[63:0]) : longint'(prod[63:0]));
      end
   endfunction

   function void push_tri(input longint p[3], input longint q[3], input longint r[3],
                          input logic last);
      tri_word_type t;
      for (int k = 0; k < 3; k++) begin
         t.f[k] = p[k][31:0];
         t.f[3+k] = q[k][31:0];
         t.f[6+k] = r[k][31:0];
      end
      t.last = last;
      pending_tris = {pending_tris, t};
   endfunction

   // note an accepted triangle and queue what it should produce
   function void note_triangle(logic signed [31:0] vin[9]);
      longint v[3][3], a[3], b[3], c[3], p[3], q[3];
      bit up[3];
      int ax, m, r;
      ax = axis_sel > 2 ? 2 : axis_sel;
      m = 0;
      r = 0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) v[i][k] = vin[i*3+k];
         up[i] = vin[i*3+ax] > plane;
         m += up[i];
      end
      if ((m == 0 && keep_lo) || (m == 3 && !keep_lo)) begin
         push_tri(v[0], v[1], v[2], 1);
         return;
      end
      if (m == 0 || m == 3) return;
      for (int i = 2; i >= 0; i--)
         if (!up[i] && up[(i+1)%3]) r = i;
      a = v[r];
      b = v[(r+1)%3];
      c = v[(r+2)%3];
      cut_edge(a, b, ax, p);
      if (m == 1) begin
         cut_edge(b, c, ax, q);
         if (keep_lo) begin
            push_tri(a, p, q, 0);
            push_tri(a, q, c, 1);
         end else begin
            push_tri(p, b, q, 1);
         end
      end else begin
         cut_edge(a, c, ax, q);
         if (keep_lo) begin
            push_tri(a, p, q, 1);
         end else begin
            push_tri(p, b, q, 0);
            push_tri(q, b, c, 1);
         end
      end
   endfunction

   function void check_tri(logic [31:0] got[9], logic got_last);
      tri_word_type t;
      bit bad;
      if (pending_tris.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result triangle");
         return;
      end
      t = pending_tris.pop_front();
      bad = (got_last !== t.last);
      for (int k = 0; k < 9; k++) if (got[k] !== t.f[k]) bad = 1;
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: exp %p last %0d", t.f, t.last);
            $display("          got %p last %0d", got, got_last);
         end
      end
   endfunction
endclass

/* tb/testbench.sv */
// testbench top: drives triangles and csr writes, checks clipped results
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tapc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tapc_req_if req_chan();
   tapc_rsp_if rsp_chan();

   triangle_axis_plane_clipper_unit dut (
      .clock, .reset, .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   tapc_scoreboard clip_board = new();

   // receiver-side knobs
   bit   sink_idle_on = 1;
   bit   long_hold    = 0;
   int   quiet_cycles = 0;

   always #5 clock = ~clock;

   initial begin
      req_chan.valid = 0;
      {req_chan.v0_x, req_chan.v0_y, req_chan.v0_z} = '0;
      {req_chan.v1_x, req_chan.v1_y, req_chan.v1_z} = '0;
      {req_chan.v2_x, req_chan.v2_y, req_chan.v2_z} = '0;
      rsp_chan.ready = 0;
   end

   // result side: check every accepted word
   always @(posedge clock) begin
      logic [31:0] got[9];
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.r0_x, rsp_chan.r0_y, rsp_chan.r0_z,
                 rsp_chan.r1_x, rsp_chan.r1_y, rsp_chan.r1_z,
                 rsp_chan.r2_x, rsp_chan.r2_y, rsp_chan.r2_z};
         clip_board.check_tri(got, rsp_chan.last_of_run);
      end
   end

   initial begin : sink_pacing
      int n;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            // hold off a long stretch so the pipe fills and stalls req
            @(posedge clock) rsp_chan.ready <= 0;
            repeat (200) @(posedge clock);
            long_hold = 0;
         end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 11);
            rsp_chan.ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1;
            @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || csr_psel)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      clip_board.set_reg(idx, val);
   endtask

   // wait until nothing is expected, then let the pipe drain
   task automatic drain_pipe();
      while (clip_board.pending_tris.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_tri(logic signed [31:0] v[9], bit idle_on);
      int n;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 11);
         req_chan.valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_chan.valid <= 1;
      {req_chan.v0_x, req_chan.v0_y, req_chan.v0_z} <= {v[0], v[1], v[2]};
      {req_chan.v1_x, req_chan.v1_y, req_chan.v1_z} <= {v[3], v[4], v[5]};
      {req_chan.v2_x, req_chan.v2_y, req_chan.v2_z} <= {v[6], v[7], v[8]};
      do @(posedge clock); while (!req_chan.ready);
      clip_board.note_triangle(v);
   endtask

   task automatic end_burst();
      req_chan.valid <= 0;
      @(posedge clock);
   endtask

   // mostly near the plane on the clip axis, within 1e6 elsewhere
   function automatic logic signed [31:0] pick_coord(logic signed [31:0] pl, bit near);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return near ? pl + $signed($urandom_range(0, 8000)) - 4000
                              : $signed($urandom_range(0, 2000000)) - 1000000;
      endcase
   endfunction

   task automatic random_phase(int count, bit idle_on);
      logic signed [31:0] v[9];
      int ax;
      ax = clip_board.axis_sel > 2 ? 2 : clip_board.axis_sel;
      for (int i = 0; i < count; i++) begin
         for (int k = 0; k < 9; k++) v[k] = pick_coord(clip_board.plane, (k % 3) == ax);
         if ($urandom_range(0, 9) == 0) v[ax] = clip_board.plane;
         send_tri(v, idle_on);
      end
      end_burst();
   endtask

   initial begin : main_flow
      logic signed [31:0] v[9];
      logic signed [31:0] planes[4];
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset config, extremes, plane hits, tiny edges, snapping
      v = '{32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh7fffffff, 0};
      send_tri(v, 0);
      v = '{-10, 5, 5, 10, 5, 5, 10, 6, 6};
      send_tri(v, 0);
      v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_tri(v, 0);
      v = '{0, 0, 0, 1, 7, 7, 0, 3, 3};
      send_tri(v, 0);
      v = '{-100000, 1, 2, 1, 3, 4, 5, 6, 7};
      send_tri(v, 0);
      v = '{-1, 100, 200, 100000, -300, 400, 200000, 5, 6};
      send_tri(v, 0);
      v = '{-5, -5, -5, -6, -6, -6, -7, -7, -7};
      send_tri(v, 0);
      v = '{5, 5, 5, 6, 6, 6, 7, 7, 7};
      send_tri(v, 0);
      v = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0};
      send_tri(v, 0);
      end_burst();
      drain_pipe();

      csr_write(REG_KEEP_BELOW, 32'd0);
      v = '{-10, 5, 5, 10, 5, 5, 10, 6, 6};
      send_tri(v, 0);
      v = '{-1, 100, 200, 100000, -300, 400, 200000, 5, 6};
      send_tri(v, 0);
      v = '{5, 5, 5, 6, 6, 6, 7, 7, 7};
      send_tri(v, 0);
      v = '{-5, -5, -5, -6, -6, -6, -7, -7, -7};
      send_tri(v, 0);
      end_burst();
      drain_pipe();

      // sweep settings, axis 3 included, with random traffic
      planes = '{32'sh80000000, 32'sh7fffffff, 0, 32'sh00012345};
      for (int ph = 0; ph < 16; ph++) begin
         csr_write(REG_CLIP_AXIS, 32'(ph % 4));
         csr_write(REG_PLANE_POSITION,
                   (ph < 4) ? planes[ph] : $signed($urandom_range(0, 600000)) - 300000);
         csr_write(REG_KEEP_BELOW, 32'($urandom_range(0, 1)));
         if (ph == 5) long_hold = 1;
         random_phase(110, ph < 13);
         if (ph == 8) drain_pipe();
         else drain_pipe();
         if (ph == 12) sink_idle_on = 0;
      end

      // axis code three acts as z, plane at the most negative value
      csr_write(REG_CLIP_AXIS, 32'd3);
      csr_write(REG_PLANE_POSITION, 32'sh80000000);
      csr_write(REG_KEEP_BELOW, 32'd1);
      random_phase(40, 0);
      drain_pipe();

      if (clip_board.mismatches == 0 && clip_board.pending_tris.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
